// ----- rtl/kscan_pkg.sv -----
// ----------------------------------------------------------------------------
// kscan_pkg
// Shared types, constants and lookup functions for the keypad scanner and
// seven-segment display multiplexer.
// ----------------------------------------------------------------------------
`default_nettype none

package kscan_pkg;

   // display geometry
   localparam int NUM_DIGITS = 4;
   localparam int POS_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

   // keypad geometry
   localparam int NUM_ROWS = 4;
   localparam int NUM_COLS = 3;

   // key codes
   localparam int CODE_W       = 4;
   localparam int NUM_PATTERNS = 12;

   typedef logic [CODE_W-1:0]   code_type;
   typedef logic [NUM_COLS-1:0] cols_type;
   typedef logic [7:0]          seg_type;
   typedef logic [POS_W-1:0]    pos_type;

   localparam code_type CODE_NONE = 4'd12;
   localparam seg_type  SEG_BLANK = 8'hFF;
   localparam pos_type  LAST_POS  = POS_W'(NUM_DIGITS - 1);

   // one snapshot of all display slots
   typedef code_type [NUM_DIGITS-1:0] frame_type;

   // queue between scanner and display
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // key code for each row and column, column 0 first
   localparam code_type KEY_MAP [NUM_ROWS][NUM_COLS] = '{
      '{4'd11, 4'd0, 4'd10},
      '{4'd9,  4'd8, 4'd7},
      '{4'd6,  4'd5, 4'd4},
      '{4'd3,  4'd2, 4'd1}
   };

   // active-low segment patterns, bit7 is the decimal point
   localparam seg_type SEG_TABLE [NUM_PATTERNS] = '{
      8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92,
      8'h82, 8'hF8, 8'h80, 8'h90, 8'hBF, 8'hF6
   };

   // segment pattern of a slot code, blank when empty or unknown
   function automatic seg_type pattern_of(input code_type code);
      seg_type result;
      result = SEG_BLANK;
      if (code < code_type'(NUM_PATTERNS)) begin
         result = SEG_TABLE[code];
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/kscan_front.sv -----
// ----------------------------------------------------------------------------
// kscan_front
// Accepts scan frames, picks the key code by priority, tracks the held flag
// and fills the digit slots; pushes a snapshot of the slots per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module kscan_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire kscan_pkg::cols_type req_row0_columns,
   input  wire kscan_pkg::cols_type req_row1_columns,
   input  wire kscan_pkg::cols_type req_row2_columns,
   input  wire kscan_pkg::cols_type req_row3_columns,
   input  wire logic                queue_full,
   output      logic                push_valid,
   output      kscan_pkg::frame_type push_frame
);
   import kscan_pkg::*;

   frame_type slots_ff, slots_in;
   logic      held_ff, held_in;
   cols_type  cols [NUM_ROWS];
   code_type  code;
   code_type  row_code;
   logic      row_hit;
   logic      placed;
   logic      accept;

   assign cols[0] = req_row0_columns;
   assign cols[1] = req_row1_columns;
   assign cols[2] = req_row2_columns;
   assign cols[3] = req_row3_columns;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // priority pick: first column in a row, later row overrides
   always_comb begin
      code     = CODE_NONE;
      row_code = CODE_NONE;
      row_hit  = 1'b0;
      for (int r = 0; r < NUM_ROWS; r++) begin
         row_hit  = 1'b0;
         row_code = CODE_NONE;
         for (int c = NUM_COLS - 1; c >= 0; c--) begin
            if (!cols[r][c]) begin
               row_hit  = 1'b1;
               row_code = KEY_MAP[r][c];
            end
         end
         if (row_hit) begin
            code = row_code;
         end
      end
   end

   // new press goes into the first empty slot
   always_comb begin
      slots_in = slots_ff;
      held_in  = held_ff;
      placed   = 1'b0;
      if (accept) begin
         if (code != CODE_NONE) begin
            if (!held_ff) begin
               for (int s = 0; s < NUM_DIGITS; s++) begin
                  if (!placed && (slots_ff[s] == CODE_NONE)) begin
                     slots_in[s] = code;
                     placed      = 1'b1;
                  end
               end
            end
            held_in = 1'b1;
         end else begin
            held_in = 1'b0;
         end
      end
   end

   assign push_valid = accept;
   assign push_frame = slots_in;

   // slot and held state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_DIGITS; s++) begin
            slots_ff[s] <= CODE_NONE;
         end
         held_ff <= 1'b0;
      end else begin
         slots_ff <= slots_in;
         held_ff  <= held_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/kscan_queue.sv -----
// ----------------------------------------------------------------------------
// kscan_queue
// Short queue of slot snapshots between the scanner front and the display
// back end.
// ----------------------------------------------------------------------------
`default_nettype none

module kscan_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   input  wire kscan_pkg::frame_type push_frame,
   output      logic                 queue_full,
   output      logic                 head_valid,
   output      kscan_pkg::frame_type head_frame,
   input  wire logic                 pop
);
   import kscan_pkg::*;

   frame_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wptr_ff, wptr_in;
   logic [QPTR_W-1:0]  rptr_ff, rptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign queue_full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_frame = entry_ff[rptr_ff];

   assign do_push = push_valid && !queue_full;
   assign do_pop  = pop && head_valid;

   // pointer and count update
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wptr_ff + 1'b1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_frame;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/kscan_back.sv -----
// ----------------------------------------------------------------------------
// kscan_back
// Walks the digits of the queued snapshot, one per cycle while rsp_stall is
// low, and drives the registered digit outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module kscan_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  wire kscan_pkg::frame_type head_frame,
   output      logic                 pop,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic [1:0]           rsp_digit_position,
   output      logic [1:0]           rsp_digit_select,
   output      kscan_pkg::seg_type   rsp_segments,
   output      logic                 rsp_last_digit
);
   import kscan_pkg::*;

   pos_type    pos_ff, pos_in;
   logic       valid_ff, valid_in;
   logic [1:0] position_ff;
   logic [1:0] select_ff;
   seg_type    segments_ff;
   logic       last_ff;
   logic       advance;
   logic       load;
   logic       at_last;

   assign advance = !valid_ff || !rsp_stall;
   assign load    = advance && head_valid;
   assign at_last = (pos_ff == LAST_POS);
   assign pop     = load && at_last;

   // digit counter and output valid
   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      if (advance) begin
         valid_in = head_valid;
      end
      if (load) begin
         pos_in = at_last ? '0 : POS_W'(pos_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   // digit payload register
   always_ff @(posedge clock) begin
      if (load) begin
         position_ff <= 2'(pos_ff);
         select_ff   <= 2'(POS_W'(LAST_POS - pos_ff));
         segments_ff <= pattern_of(head_frame[pos_ff]);
         last_ff     <= at_last;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_digit_position = position_ff;
   assign rsp_digit_select   = select_ff;
   assign rsp_segments       = segments_ff;
   assign rsp_last_digit     = last_ff;

endmodule

`default_nettype wire

// ----- rtl/keypad_scan_to_seven_segment.sv -----
// ----------------------------------------------------------------------------
// keypad_scan_to_seven_segment
// Keypad scanner storing up to four presses, with a multiplexed display.
// ----------------------------------------------------------------------------
// Input channel (req_): one scan frame of a 4x3 keypad per item, three
// active-low column readings per row. The key code is chosen by priority and
// a new press fills the first empty of four slots.
// Result channel (rsp_): four digit items per frame, slot 0 first, each with
// position, select lines, active-low segments and a last-digit flag.
// Order: the accepted frame's slot snapshot is registered in the queue, then
// each digit in the output register; the remaining three follow in order.
// Rate: one digit per cycle from the output register while rsp_stall is
// low. A two-entry queue of slot snapshots sits between scanner and
// display, so new frames are taken while digits of earlier ones drain.
// Reset: all slots empty (shown blank), held flag clear, queue empty, no
// output valid.
// Receiver stall: the current digit holds; once the queue is full req_stall
// rises and further frames wait.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_scan_to_seven_segment (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire kscan_pkg::cols_type req_row0_columns,
   input  wire kscan_pkg::cols_type req_row1_columns,
   input  wire kscan_pkg::cols_type req_row2_columns,
   input  wire kscan_pkg::cols_type req_row3_columns,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [1:0]          rsp_digit_position,
   output      logic [1:0]          rsp_digit_select,
   output      kscan_pkg::seg_type  rsp_segments,
   output      logic                rsp_last_digit
);
   import kscan_pkg::*;

   logic      push_valid;
   frame_type push_frame;
   logic      queue_full;
   logic      head_valid;
   frame_type head_frame;
   logic      pop;

   // scanner front
   kscan_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_row0_columns (req_row0_columns),
      .req_row1_columns (req_row1_columns),
      .req_row2_columns (req_row2_columns),
      .req_row3_columns (req_row3_columns),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_frame       (push_frame)
   );

   // snapshot queue
   kscan_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_frame (push_frame),
      .queue_full (queue_full),
      .head_valid (head_valid),
      .head_frame (head_frame),
      .pop        (pop)
   );

   // display back end
   kscan_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_frame         (head_frame),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digit_position (rsp_digit_position),
      .rsp_digit_select   (rsp_digit_select),
      .rsp_segments       (rsp_segments),
      .rsp_last_digit     (rsp_last_digit)
   );

endmodule

`default_nettype wire
